// ----- design/dspfs_pkg.sv -----
// Shared constants, register and fault types for the drive state pedal fault supervisor.
`default_nettype none

package dspfs_pkg;

  // Default widths
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF  = 10;

  // Fixed widths
  localparam int REG_W        = 10;
  localparam int CFG_IDX_W    = 8;
  localparam int THR_W        = 8;
  localparam int STATE_CODE_W = 3;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_PEDAL_DIFF_LIMIT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DISAGREE_FAULT_TICKS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LOW_COUNT      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HIGH_COUNT     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PLAUS_SET_THROTTLE   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_PLAUS_CLEAR_THROTTLE = CFG_IDX_W'(5);

  // Register reset values (0.5 V and 4.5 V of a 5 V, 10-bit range; 25 % and 5 % pedal)
  localparam logic [REG_W-1:0] PEDAL_DIFF_LIMIT_RST     = REG_W'(102);
  localparam logic [REG_W-1:0] DISAGREE_FAULT_TICKS_RST = REG_W'(100);
  localparam logic [REG_W-1:0] BRAKE_LOW_COUNT_RST      = REG_W'(102);
  localparam logic [REG_W-1:0] BRAKE_HIGH_COUNT_RST     = REG_W'(920);
  localparam logic [REG_W-1:0] PLAUS_SET_THROTTLE_RST   = REG_W'(255);
  localparam logic [REG_W-1:0] PLAUS_CLEAR_THROTTLE_RST = REG_W'(52);

  // Drive state codes as shown on the result channel
  localparam logic [STATE_CODE_W-1:0] SC_STANDBY   = STATE_CODE_W'(0);
  localparam logic [STATE_CODE_W-1:0] SC_TS_ACTIVE = STATE_CODE_W'(1);
  localparam logic [STATE_CODE_W-1:0] SC_READY     = STATE_CODE_W'(2);
  localparam logic [STATE_CODE_W-1:0] SC_DRIVING   = STATE_CODE_W'(3);
  localparam logic [STATE_CODE_W-1:0] SC_FAULT     = STATE_CODE_W'(4);

  // Threshold registers
  typedef struct packed {
    logic [REG_W-1:0] pedal_diff_limit;
    logic [REG_W-1:0] disagree_fault_ticks;
    logic [REG_W-1:0] brake_low_count;
    logic [REG_W-1:0] brake_high_count;
    logic [REG_W-1:0] plaus_set_throttle;
    logic [REG_W-1:0] plaus_clear_throttle;
  } cfg_regs_t;

  // Per-tick fault evaluation handed to the state machine
  typedef struct packed {
    logic             apps;        // pedal disagreement fault
    logic             bse;         // brake out of range
    logic             plaus;       // latched throttle-while-braking fault
    logic             any;
    logic             brake_under; // brake at or below the low count
    logic             brake_over;  // brake above the high count
    logic [THR_W-1:0] throttle;    // pedal average / 4, saturated
  } fault_info_t;

endpackage

`default_nettype wire

// ----- design/dspfs_if.sv -----
// Channel interfaces: tick input, result output and register write.
`default_nettype none

interface dspfs_in_if
  import dspfs_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pedal_a;
  logic [SAMPLE_BITS-1:0] pedal_b;
  logic [SAMPLE_BITS-1:0] brake_sample;
  logic                   tractive_active;
  logic                   key_on;

  modport source (output valid, pedal_a, pedal_b, brake_sample, tractive_active, key_on,
                  input ready);
  modport sink   (input valid, pedal_a, pedal_b, brake_sample, tractive_active, key_on,
                  output ready);
endinterface

interface dspfs_out_if
  import dspfs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [STATE_CODE_W-1:0] state_code;
  logic                    motor_enable;
  logic [THR_W-1:0]        throttle_drive;
  logic                    buzzer_start;
  logic                    buzzer_stop;
  logic                    pedal_disagree_fault;
  logic                    brake_range_fault;
  logic                    pedal_brake_fault;

  modport source (output valid, state_code, motor_enable, throttle_drive, buzzer_start,
                  buzzer_stop, pedal_disagree_fault, brake_range_fault, pedal_brake_fault,
                  input ready);
  modport sink   (input valid, state_code, motor_enable, throttle_drive, buzzer_start,
                  buzzer_stop, pedal_disagree_fault, brake_range_fault, pedal_brake_fault,
                  output ready);
endinterface

interface dspfs_cfg_if
  import dspfs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/dspfs_faults.sv -----
// Fault evaluation: pedal disagreement counter, brake range and plausibility latch.
`default_nettype none

module dspfs_faults
  import dspfs_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire logic [SAMPLE_BITS-1:0] pedal_a,
  input  wire logic [SAMPLE_BITS-1:0] pedal_b,
  input  wire logic [SAMPLE_BITS-1:0] brake_sample,
  input  wire cfg_regs_t              regs,
  output fault_info_t                 info
);

  localparam int CMP_W     = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
  localparam int CNT_CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] THR_SAT   = SAMPLE_BITS'((1 << THR_W) - 1);

  logic [COUNT_BITS-1:0]  disagree_count;
  logic [COUNT_BITS-1:0]  disagree_count_next;
  logic                   plaus_latch;
  logic                   plaus_latch_next;

  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] thr_full;
  logic                   agree;
  logic                   brake_under;
  logic                   brake_over;

  // Pedal average and difference
  assign diff     = (pedal_a >= pedal_b) ? (pedal_a - pedal_b) : (pedal_b - pedal_a);
  assign sum      = {1'b0, pedal_a} + {1'b0, pedal_b};
  assign avg      = sum[SAMPLE_BITS:1];
  assign thr_full = avg >> 2;

  // Disagreement counter, saturating
  assign agree = CMP_W'(diff) <= CMP_W'(regs.pedal_diff_limit);
  always_comb begin
    if (agree) begin
      disagree_count_next = '0;
    end else if (disagree_count != COUNT_MAX) begin
      disagree_count_next = disagree_count + 1'b1;
    end else begin
      disagree_count_next = disagree_count;
    end
  end

  // Brake range
  assign brake_under = CMP_W'(brake_sample) <= CMP_W'(regs.brake_low_count);
  assign brake_over  = CMP_W'(brake_sample) > CMP_W'(regs.brake_high_count);

  // Plausibility latch with set/clear hysteresis
  always_comb begin
    if (plaus_latch) begin
      plaus_latch_next = !(CMP_W'(avg) < CMP_W'(regs.plaus_clear_throttle));
    end else begin
      plaus_latch_next = (CMP_W'(avg) > CMP_W'(regs.plaus_set_throttle)) && !brake_under;
    end
  end

  always_comb begin
    info.apps        = CNT_CMP_W'(disagree_count_next) >= CNT_CMP_W'(regs.disagree_fault_ticks);
    info.bse         = brake_under || brake_over;
    info.plaus       = plaus_latch_next;
    info.any         = info.apps || info.bse || info.plaus;
    info.brake_under = brake_under;
    info.brake_over  = brake_over;
    info.throttle    = (thr_full > THR_SAT) ? {THR_W{1'b1}} : THR_W'(thr_full);
  end

  // State update once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      disagree_count <= '0;
      plaus_latch    <= 1'b0;
    end else if (advance) begin
      disagree_count <= disagree_count_next;
      plaus_latch    <= plaus_latch_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/drive_state_pedal_fault_supervisor.sv -----
// Top level: tick input register, fault evaluation, drive state machine, result register.
//
//  channel  | dir | transfer carries
//  ---------+-----+-----------------------------------------------------------
//  sample   | in  | pedal_a, pedal_b, brake_sample, tractive_active, key_on
//  result   | out | state_code, motor_enable, throttle_drive, buzzer pulses, faults
//  cfg      | in  | index, data (threshold register write, always ready)
//
//  One tick per cycle sustained unless result stalls; results are registered.
//  The input register and the result register each hold one tick, so a new tick is
//  taken while a finished result waits. A stall on result backs up into sample.
//  Synchronous reset returns to standby, clears the counter and the latch, and
//  loads the threshold register defaults.
`default_nettype none

module drive_state_pedal_fault_supervisor
  import dspfs_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dspfs_in_if.sink    sample,
  dspfs_out_if.source result,
  dspfs_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    ST_STANDBY   = 5'b00001,
    ST_TS_ACTIVE = 5'b00010,
    ST_READY     = 5'b00100,
    ST_DRIVING   = 5'b01000,
    ST_FAULT     = 5'b10000
  } drive_state_t;

  cfg_regs_t              regs;

  // Input stage
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_pedal_a;
  logic [SAMPLE_BITS-1:0] s1_pedal_b;
  logic [SAMPLE_BITS-1:0] s1_brake;
  logic                   s1_ts;
  logic                   s1_key;
  logic                   s1_advance;
  logic                   in_xfer;

  fault_info_t            info;
  drive_state_t           drive_state;
  drive_state_t           fsm_next;
  drive_state_t           drive_state_next;
  logic                   start_next;
  logic                   stop_next;
  logic [STATE_CODE_W-1:0] code_next;

  // Result register
  logic                    out_valid;
  logic [STATE_CODE_W-1:0] out_state_code;
  logic                    out_motor_enable;
  logic [THR_W-1:0]        out_throttle;
  logic                    out_start;
  logic                    out_stop;
  logic                    out_apps;
  logic                    out_bse;
  logic                    out_plaus;

  // Register writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pedal_diff_limit     <= PEDAL_DIFF_LIMIT_RST;
      regs.disagree_fault_ticks <= DISAGREE_FAULT_TICKS_RST;
      regs.brake_low_count      <= BRAKE_LOW_COUNT_RST;
      regs.brake_high_count     <= BRAKE_HIGH_COUNT_RST;
      regs.plaus_set_throttle   <= PLAUS_SET_THROTTLE_RST;
      regs.plaus_clear_throttle <= PLAUS_CLEAR_THROTTLE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PEDAL_DIFF_LIMIT:     regs.pedal_diff_limit     <= cfg.data;
        REG_DISAGREE_FAULT_TICKS: regs.disagree_fault_ticks <= cfg.data;
        REG_BRAKE_LOW_COUNT:      regs.brake_low_count      <= cfg.data;
        REG_BRAKE_HIGH_COUNT:     regs.brake_high_count     <= cfg.data;
        REG_PLAUS_SET_THROTTLE:   regs.plaus_set_throttle   <= cfg.data;
        REG_PLAUS_CLEAR_THROTTLE: regs.plaus_clear_throttle <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the result register is free or being drained
  assign s1_advance   = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;
  assign in_xfer      = sample.valid && sample.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pedal_a <= sample.pedal_a;
      s1_pedal_b <= sample.pedal_b;
      s1_brake   <= sample.brake_sample;
      s1_ts      <= sample.tractive_active;
      s1_key     <= sample.key_on;
    end
  end

  dspfs_faults #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_faults (
    .clk          (clk),
    .rst          (rst),
    .advance      (s1_advance),
    .pedal_a      (s1_pedal_a),
    .pedal_b      (s1_pedal_b),
    .brake_sample (s1_brake),
    .regs         (regs),
    .info         (info)
  );

  // Ready-to-drive state machine
  always_comb begin
    fsm_next   = drive_state;
    start_next = 1'b0;
    stop_next  = 1'b0;
    case (drive_state)
      ST_STANDBY: begin
        if (s1_ts) fsm_next = ST_TS_ACTIVE;
      end
      ST_TS_ACTIVE: begin
        if (!info.brake_under && !info.brake_over) begin
          fsm_next   = ST_READY;
          start_next = 1'b1;
        end else if (!s1_ts) begin
          fsm_next  = ST_STANDBY;
          stop_next = 1'b1;
        end
      end
      ST_READY: begin
        if (s1_key) begin
          fsm_next = ST_DRIVING;
        end else if (!s1_ts) begin
          fsm_next  = ST_STANDBY;
          stop_next = 1'b1;
        end else if (info.brake_under) begin
          fsm_next = ST_TS_ACTIVE;
        end
      end
      ST_DRIVING: begin
        if (!s1_ts) fsm_next = ST_STANDBY;
        else if (!s1_key) fsm_next = ST_READY;
      end
      ST_FAULT: ;
      default: fsm_next = ST_STANDBY;
    endcase
  end

  // Fault override
  always_comb begin
    drive_state_next = fsm_next;
    if (info.any && fsm_next == ST_DRIVING) drive_state_next = ST_FAULT;
    if (!info.any && fsm_next == ST_FAULT) drive_state_next = ST_DRIVING;
  end

  always_comb begin
    case (drive_state_next)
      ST_STANDBY:   code_next = SC_STANDBY;
      ST_TS_ACTIVE: code_next = SC_TS_ACTIVE;
      ST_READY:     code_next = SC_READY;
      ST_DRIVING:   code_next = SC_DRIVING;
      ST_FAULT:     code_next = SC_FAULT;
      default:      code_next = SC_STANDBY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_state <= ST_STANDBY;
    end else if (s1_advance) begin
      drive_state <= drive_state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_state_code   <= code_next;
      out_motor_enable <= !info.any;
      out_throttle     <= info.any ? '0 : info.throttle;
      out_start        <= start_next;
      out_stop         <= stop_next;
      out_apps         <= info.apps;
      out_bse          <= info.bse;
      out_plaus        <= info.plaus;
    end
  end

  assign result.valid                = out_valid;
  assign result.state_code           = out_state_code;
  assign result.motor_enable         = out_motor_enable;
  assign result.throttle_drive       = out_throttle;
  assign result.buzzer_start         = out_start;
  assign result.buzzer_stop          = out_stop;
  assign result.pedal_disagree_fault = out_apps;
  assign result.brake_range_fault    = out_bse;
  assign result.pedal_brake_fault    = out_plaus;

endmodule

`default_nettype wire

// ----- design/dspfs_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module dspfs_checker
  import dspfs_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [STATE_CODE_W-1:0] state_code,
  input wire logic                    motor_enable,
  input wire logic [THR_W-1:0]        throttle_drive,
  input wire logic                    buzzer_start,
  input wire logic                    buzzer_stop,
  input wire logic                    apps_fault,
  input wire logic                    bse_fault,
  input wire logic                    plaus_fault
);

  // Motor enable is exactly the absence of all three faults
  a_enable_vs_faults: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_enable == !(apps_fault || bse_fault || plaus_fault)))
    else $error("motor_enable disagrees with fault flags");

  // No throttle while the motor is disabled
  a_throttle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !motor_enable) |-> (throttle_drive == '0))
    else $error("throttle present under fault");

  // Buzzer start only on entering ready, never together with stop
  a_start_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buzzer_start) |-> (state_code == SC_READY && !buzzer_stop))
    else $error("buzzer start outside ready entry");

  // Fault state and driving follow the fault flags
  a_fault_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (state_code == SC_FAULT || state_code == SC_DRIVING)) |->
      ((state_code == SC_FAULT) == !motor_enable))
    else $error("fault state inconsistent with motor enable");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(state_code) && $stable(throttle_drive)))
    else $error("stalled result changed");

endmodule

bind drive_state_pedal_fault_supervisor dspfs_checker u_dspfs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .state_code     (result.state_code),
  .motor_enable   (result.motor_enable),
  .throttle_drive (result.throttle_drive),
  .buzzer_start   (result.buzzer_start),
  .buzzer_stop    (result.buzzer_stop),
  .apps_fault     (result.pedal_disagree_fault),
  .bse_fault      (result.brake_range_fault),
  .plaus_fault    (result.pedal_brake_fault)
);

`default_nettype wire
